// ----- rtl/ssfd_pkg.sv -----
// Shared types and constants for the sensor stream frame deframer.
// No dependencies; every other rtl file but ssfd_ram uses it by scoped names.
package ssfd_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int IDX_W       = $clog2(MAX_PAYLOAD);
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int BANKS       = 2;
    localparam int RAM_DEPTH   = BANKS * MAX_PAYLOAD;
    localparam int RAM_AW      = $clog2(RAM_DEPTH);

    localparam logic [7:0]       SYNC_RESET = 8'd19;
    localparam logic [7:0]       ID_RESET   = 8'd6;
    localparam logic [CNT_W-1:0] LEN_RESET  = CNT_W'(52);

    localparam logic [1:0] CFG_SYNC = 2'd0;
    localparam logic [1:0] CFG_ID   = 2'd1;
    localparam logic [1:0] CFG_LEN  = 2'd2;

    typedef enum logic [2:0] {
        F_HUNT,
        F_LEN,
        F_ID,
        F_DATA,
        F_SUM
    } t_fphase;

    typedef enum logic [1:0] {
        B_IDLE,
        B_FETCH,
        B_CAP,
        B_OUT
    } t_bstate;

    typedef struct packed {
        logic             err;
        logic             bank;
        logic [IDX_W-1:0] last_idx;
    } t_cmd;

endpackage

// ----- rtl/ssfd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ssfd_front.sv -----
// Front end: configuration registers, frame hunt and header checks, payload write
// and checksum. Pushes one command per checksum beat. Uses ssfd_pkg.
module ssfd_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [7:0]                 i_cfg_data,
    input  logic                       i_rx_valid,
    output logic                       o_rx_ready,
    input  logic [7:0]                 i_rx_byte,
    output logic                       o_we,
    output logic [ssfd_pkg::RAM_AW-1:0] o_waddr,
    output logic [7:0]                 o_wdata,
    output logic                       o_push,
    output ssfd_pkg::t_cmd             o_cmd,
    input  logic                       i_q_full,
    input  logic                       i_release
);

    localparam int CW = ssfd_pkg::CNT_W;
    localparam int IW = ssfd_pkg::IDX_W;

    logic [7:0]    r_sync;
    logic [7:0]    r_id;
    logic [CW-1:0] r_plen;

    ssfd_pkg::t_fphase r_phase, n_phase;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_sum, n_sum;
    logic          r_bank, n_bank;
    logic [1:0]    r_busy, n_busy;

    logic [CW-1:0] len;
    logic [7:0]    len_p1;
    logic [7:0]    sum_b;
    logic [CW-1:0] cnt_inc;
    logic          accept;
    logic          push_good;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= ssfd_pkg::SYNC_RESET;
            r_id   <= ssfd_pkg::ID_RESET;
            r_plen <= ssfd_pkg::LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ssfd_pkg::CFG_SYNC: r_sync <= i_cfg_data;
                ssfd_pkg::CFG_ID:   r_id   <= i_cfg_data;
                ssfd_pkg::CFG_LEN:  r_plen <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ssfd_pkg::F_HUNT;
            r_cnt   <= '0;
            r_sum   <= '0;
            r_bank  <= 1'b0;
            r_busy  <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
            r_bank  <= n_bank;
            r_busy  <= n_busy;
        end
    end

    always_comb begin
        if (r_plen == '0) begin
            len = CW'(1);
        end else if (r_plen > CW'(ssfd_pkg::MAX_PAYLOAD)) begin
            len = CW'(ssfd_pkg::MAX_PAYLOAD);
        end else begin
            len = r_plen;
        end
    end

    assign len_p1  = 8'(len) + 8'd1;
    assign sum_b   = r_sum + i_rx_byte;
    assign cnt_inc = (r_cnt < CW'(ssfd_pkg::MAX_PAYLOAD)) ? r_cnt + CW'(1) : r_cnt;

    always_comb begin
        o_rx_ready = 1'b1;
        if (r_phase == ssfd_pkg::F_DATA && r_busy == 2'd2) begin
            o_rx_ready = 1'b0;
        end
        if (r_phase == ssfd_pkg::F_SUM && i_q_full) begin
            o_rx_ready = 1'b0;
        end
    end

    assign accept = i_rx_valid && o_rx_ready;

    always_comb begin
        n_phase      = r_phase;
        n_cnt        = r_cnt;
        n_sum        = r_sum;
        n_bank       = r_bank;
        o_we         = 1'b0;
        o_waddr      = {r_bank, r_cnt[IW-1:0]};
        o_wdata      = i_rx_byte;
        o_push       = 1'b0;
        o_cmd.err    = (sum_b != 8'd0);
        o_cmd.bank   = r_bank;
        o_cmd.last_idx = IW'(r_cnt - CW'(1));
        push_good    = 1'b0;
        if (accept) begin
            unique case (r_phase)
                ssfd_pkg::F_HUNT: begin
                    if (i_rx_byte == r_sync) begin
                        n_sum   = i_rx_byte;
                        n_cnt   = '0;
                        n_phase = ssfd_pkg::F_LEN;
                    end
                end
                ssfd_pkg::F_LEN: begin
                    if (i_rx_byte == len_p1) begin
                        n_sum   = sum_b;
                        n_phase = ssfd_pkg::F_ID;
                    end else begin
                        n_phase = ssfd_pkg::F_HUNT;
                    end
                end
                ssfd_pkg::F_ID: begin
                    if (i_rx_byte == r_id) begin
                        n_sum   = sum_b;
                        n_cnt   = '0;
                        n_phase = ssfd_pkg::F_DATA;
                    end else begin
                        n_phase = ssfd_pkg::F_HUNT;
                    end
                end
                ssfd_pkg::F_DATA: begin
                    o_we  = (r_cnt < CW'(ssfd_pkg::MAX_PAYLOAD));
                    n_cnt = cnt_inc;
                    n_sum = sum_b;
                    if (cnt_inc >= len) begin
                        n_phase = ssfd_pkg::F_SUM;
                    end
                end
                ssfd_pkg::F_SUM: begin
                    n_sum     = sum_b;
                    o_push    = 1'b1;
                    push_good = (sum_b == 8'd0);
                    n_phase   = ssfd_pkg::F_HUNT;
                end
                default: n_phase = ssfd_pkg::F_HUNT;
            endcase
        end
        if (push_good) begin
            n_bank = ~r_bank;
        end
        n_busy = r_busy + 2'(push_good) - 2'(i_release);
    end

endmodule

// ----- rtl/ssfd_queue.sv -----
// Two-entry command queue between front and back ends.
// Uses ssfd_pkg for the command type.
module ssfd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ssfd_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output ssfd_pkg::t_cmd o_cmd
);

    ssfd_pkg::t_cmd r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ----- rtl/ssfd_back.sv -----
// Back end: pops commands, reads the stored payload and drives the result beats.
// Uses ssfd_pkg.
module ssfd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  ssfd_pkg::t_cmd              i_cmd,
    output logic                        o_pop,
    output logic                        o_re,
    output logic [ssfd_pkg::RAM_AW-1:0] o_raddr,
    input  logic [7:0]                  i_rdata,
    output logic                        o_release,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic [7:0]                  o_payload_byte,
    output logic [ssfd_pkg::IDX_W-1:0]  o_byte_index,
    output logic                        o_last,
    output logic                        o_frame_status
);

    localparam int IW = ssfd_pkg::IDX_W;

    ssfd_pkg::t_bstate r_state, n_state;
    ssfd_pkg::t_cmd    r_cmd, n_cmd;
    logic [IW-1:0]     r_idx, n_idx;
    logic [7:0]        r_byte, n_byte;
    logic [IW-1:0]     r_oidx, n_oidx;
    logic              r_last, n_last;
    logic              r_status, n_status;
    logic              beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssfd_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_idx    <= n_idx;
        r_byte   <= n_byte;
        r_oidx   <= n_oidx;
        r_last   <= n_last;
        r_status <= n_status;
    end

    assign beat = (r_state == ssfd_pkg::B_OUT) && i_res_ready;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_idx     = r_idx;
        n_byte    = r_byte;
        n_oidx    = r_oidx;
        n_last    = r_last;
        n_status  = r_status;
        o_pop     = 1'b0;
        o_re      = 1'b0;
        o_raddr   = {r_cmd.bank, r_idx};
        o_release = 1'b0;
        unique case (r_state)
            ssfd_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    n_idx = '0;
                    if (i_cmd.err) begin
                        n_byte   = 8'd0;
                        n_oidx   = '0;
                        n_last   = 1'b1;
                        n_status = 1'b1;
                        n_state  = ssfd_pkg::B_OUT;
                    end else begin
                        n_state = ssfd_pkg::B_FETCH;
                    end
                end
            end
            ssfd_pkg::B_FETCH: begin
                o_re    = 1'b1;
                n_state = ssfd_pkg::B_CAP;
            end
            ssfd_pkg::B_CAP: begin
                n_byte   = i_rdata;
                n_oidx   = r_idx;
                n_last   = (r_idx == r_cmd.last_idx);
                n_status = 1'b0;
                n_state  = ssfd_pkg::B_OUT;
            end
            ssfd_pkg::B_OUT: begin
                if (beat) begin
                    if (r_last) begin
                        o_release = !r_status;
                        n_state   = ssfd_pkg::B_IDLE;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = ssfd_pkg::B_FETCH;
                    end
                end
            end
            default: n_state = ssfd_pkg::B_IDLE;
        endcase
    end

    assign o_res_valid    = (r_state == ssfd_pkg::B_OUT);
    assign o_payload_byte = r_byte;
    assign o_byte_index   = r_oidx;
    assign o_last         = r_last;
    assign o_frame_status = r_status;

endmodule

// ----- rtl/sensor_stream_frame_deframer.sv -----
// Top level of the sensor stream frame deframer: front end, command queue, back end
// and a two-bank payload RAM. Uses ssfd_pkg and all ssfd_* modules.
//
// One received byte is taken per cycle as long as the front end is not held: it
// stalls on a payload byte while both payload banks still await readout, and on the
// checksum byte while the two-entry command queue is full. A verified frame of N
// bytes is released as N result beats: the first follows the queue pop through the
// states pop, RAM read, capture and output register, and each further beat follows
// the taking of the previous one through index step with RAM read, capture and
// output register; a checksum failure gives one beat, presented on the cycle after
// the pop.
// Writing the next frame into the second bank overlaps readout of the previous one,
// so input and output sides stall independently.
module sensor_stream_frame_deframer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [7:0]                 i_cfg_data,
    input  logic                       i_rx_valid,
    output logic                       o_rx_ready,
    input  logic [7:0]                 i_rx_byte,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output logic [7:0]                 o_payload_byte,
    output logic [ssfd_pkg::IDX_W-1:0] o_byte_index,
    output logic                       o_last,
    output logic                       o_frame_status
);

    logic                        we;
    logic [ssfd_pkg::RAM_AW-1:0] waddr;
    logic [7:0]                  wdata;
    logic                        re;
    logic [ssfd_pkg::RAM_AW-1:0] raddr;
    logic [7:0]                  rdata;
    logic                        push, pop, q_full, q_empty, release_bank;
    ssfd_pkg::t_cmd              push_cmd, head_cmd;

    ssfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_rx_byte  (i_rx_byte),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .i_q_full   (q_full),
        .i_release  (release_bank)
    );

    ssfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    ssfd_ram #(
        .WIDTH (8),
        .DEPTH (ssfd_pkg::RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ssfd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_cmd          (head_cmd),
        .o_pop          (pop),
        .o_re           (re),
        .o_raddr        (raddr),
        .i_rdata        (rdata),
        .o_release      (release_bank),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_last         (o_last),
        .o_frame_status (o_frame_status)
    );

endmodule

// ----- rtl/ssfd_checker.sv -----
// Port-level checks for sensor_stream_frame_deframer, bound to the top level.
// Uses ssfd_pkg for the index width.
module ssfd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_res_valid,
    input logic                       i_res_ready,
    input logic [7:0]                 o_payload_byte,
    input logic [ssfd_pkg::IDX_W-1:0] o_byte_index,
    input logic                       o_last,
    input logic                       o_frame_status
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_payload_byte)
            && $stable(o_byte_index) && $stable(o_last) && $stable(o_frame_status))
        else $error("result beat changed while stalled");

    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_frame_status |->
            o_last && o_payload_byte == 8'd0 && o_byte_index == '0)
        else $error("checksum error beat malformed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_ready |=> !o_res_valid)
        else $error("back-to-back result beats");

endmodule

bind sensor_stream_frame_deframer ssfd_checker u_ssfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_res_valid    (o_res_valid),
    .i_res_ready    (i_res_ready),
    .o_payload_byte (o_payload_byte),
    .o_byte_index   (o_byte_index),
    .o_last         (o_last),
    .o_frame_status (o_frame_status)
);
